FILE: sv/zsc_pkg.sv
// Package of sizes, codes and types for the zero-selector coefficient codec.
package zsc_pkg;

    // Frame and selector store dimensions
    localparam int COEFFS_PER_FRAME = 512;
    localparam int SELECTOR_BITS    = 64;
    localparam int SELECTOR_BYTES   = 8;

    // Derived widths
    localparam int ZC_W  = $clog2(SELECTOR_BITS + 1);
    localparam int IDX_W = ZC_W - 3;
    localparam int FP_W  = $clog2(COEFFS_PER_FRAME);
    localparam int LP_W  = (SELECTOR_BYTES > 1) ? $clog2(SELECTOR_BYTES) : 1;
    localparam int DC_W  = $clog2(SELECTOR_BYTES + 1);

    // Input mode codes
    localparam logic [1:0] MODE_ENCODE = 2'd0;
    localparam logic [1:0] MODE_LOAD   = 2'd1;
    localparam logic [1:0] MODE_DECODE = 2'd2;

    // Result kind codes
    localparam logic [1:0] KIND_CODED    = 2'd0;
    localparam logic [1:0] KIND_SELECTOR = 2'd1;
    localparam logic [1:0] KIND_DECODED  = 2'd2;

    typedef logic [7:0] sel_byte_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [8:0] coeff;
        logic       ovf;
        logic       last;
    } result_t;

endpackage

FILE: sv/zero_selector_coeff_codec.sv
// Top level of the zero-selector coefficient codec: encode, selector load and decode.
//
// Usage:
//   Input channel (in_valid/in_ready) carries mode, coeff_in and code_byte.
//   Output channel (out_valid/out_ready) carries result_kind, data_byte,
//   coeff_out, overflow and last.
//   Mode 0 encodes a coefficient into its low byte; zero low bytes record
//   bit 8 in the selector store. Mode 1 loads a selector byte. Mode 2 decodes
//   a code byte into a coefficient. Mode 3 is ignored.
// Output: each result is written to the output register at the clock edge that
//   accepts its input beat.
// Throughput: one input beat per cycle while the output is not stalled and no
//   selector drain is pending. The final encode beat of a frame that has not
//   overflowed is followed by SELECTOR_BYTES selector beats drained from a
//   snapshot shift register; input is held off for those SELECTOR_BYTES
//   output beats.
// Stall: the output register holds its beat while out_ready is low; a new
//   input beat is taken when the output register empties and no drain is pending.
// Reset: rst_n clears the selector store, all counters, the failure flag,
//   the drain count and the output valid.
module zero_selector_coeff_codec
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [8:0] coeff_in,
    input  logic [7:0] code_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] result_kind,
    output logic [7:0] data_byte,
    output logic [8:0] coeff_out,
    output logic       overflow,
    output logic       last
);

    zsc_pkg::sel_byte_t store_reg  [zsc_pkg::SELECTOR_BYTES];
    zsc_pkg::sel_byte_t store_next [zsc_pkg::SELECTOR_BYTES];
    zsc_pkg::sel_byte_t drain_fill [zsc_pkg::SELECTOR_BYTES];
    zsc_pkg::sel_byte_t drain_reg  [zsc_pkg::SELECTOR_BYTES];

    logic [zsc_pkg::ZC_W-1:0] zc_reg, zc_next;
    logic [zsc_pkg::FP_W-1:0] fp_reg, fp_next;
    logic [zsc_pkg::LP_W-1:0] lp_reg, lp_next;
    logic                     failed_reg, failed_next;
    logic [zsc_pkg::DC_W-1:0] drain_cnt_reg;
    logic                     out_valid_reg;
    zsc_pkg::result_t         out_reg;

    zsc_pkg::result_t         res;
    logic                     res_valid;
    logic                     snap;
    logic                     frame_end;
    logic                     in_fire;
    logic                     slot_free;
    logic                     drain_pop;

    logic [zsc_pkg::IDX_W-1:0] zc_idx;
    logic [2:0]                zc_pos;
    logic [7:0]                rd_byte;
    logic [zsc_pkg::FP_W:0]    fp_inc;
    logic                      fp_last;
    logic [zsc_pkg::LP_W:0]    lp_inc;
    logic                      zc_full;
    logic [8:0]                dec_val;

    // Handshake
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = slot_free && (drain_cnt_reg == '0);
    assign in_fire   = in_valid && in_ready;
    assign drain_pop = slot_free && (drain_cnt_reg != '0);

    // Counter arithmetic
    assign zc_idx  = zc_reg[zsc_pkg::ZC_W-1:3];
    assign zc_pos  = zc_reg[2:0];
    assign zc_full = (int'(zc_reg) >= zsc_pkg::SELECTOR_BITS);
    assign fp_inc  = {1'b0, fp_reg} + 1'b1;
    assign fp_last = (int'(fp_inc) >= zsc_pkg::COEFFS_PER_FRAME);
    assign lp_inc  = {1'b0, lp_reg} + 1'b1;

    // Read the selector byte addressed by the zero count; out of range reads zero
    always_comb
    begin
        rd_byte = '0;
        for (int b = 0; b < zsc_pkg::SELECTOR_BYTES; b++)
        begin
            if (int'(zc_idx) == b)
            begin
                rd_byte = store_reg[b];
            end
        end
    end

    // Next state and result of an accepted beat
    always_comb
    begin
        store_next  = store_reg;
        zc_next     = zc_reg;
        fp_next     = fp_reg;
        lp_next     = lp_reg;
        failed_next = failed_reg;
        res         = '0;
        res_valid   = 1'b0;
        snap        = 1'b0;
        frame_end   = 1'b0;
        dec_val     = {1'b0, code_byte};
        if (in_fire)
        begin
            unique case (mode)
                zsc_pkg::MODE_ENCODE:
                begin
                    fp_next   = fp_inc[zsc_pkg::FP_W-1:0];
                    frame_end = fp_last;
                    if (failed_reg)
                    begin
                        // swallow the rest of a failed frame
                    end
                    else if (coeff_in[7:0] == 8'd0 && zc_full)
                    begin
                        res.kind    = zsc_pkg::KIND_CODED;
                        res.ovf     = 1'b1;
                        res.last    = 1'b1;
                        res_valid   = 1'b1;
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        if (coeff_in[7:0] == 8'd0)
                        begin
                            for (int b = 0; b < zsc_pkg::SELECTOR_BYTES; b++)
                            begin
                                if (int'(zc_idx) == b)
                                begin
                                    store_next[b] = store_reg[b]
                                                  | (8'(coeff_in[8]) << zc_pos);
                                end
                            end
                            zc_next = zc_reg + 1'b1;
                        end
                        res.kind  = zsc_pkg::KIND_CODED;
                        res.data  = coeff_in[7:0];
                        res_valid = 1'b1;
                        snap      = fp_last;
                    end
                end
                zsc_pkg::MODE_LOAD:
                begin
                    for (int b = 0; b < zsc_pkg::SELECTOR_BYTES; b++)
                    begin
                        if (int'(lp_reg) == b)
                        begin
                            store_next[b] = code_byte;
                        end
                    end
                    if (int'(lp_inc) >= zsc_pkg::SELECTOR_BYTES)
                    begin
                        lp_next = '0;
                    end
                    else
                    begin
                        lp_next = lp_inc[zsc_pkg::LP_W-1:0];
                    end
                end
                zsc_pkg::MODE_DECODE:
                begin
                    if (code_byte == 8'd0 && !zc_full)
                    begin
                        dec_val[8] = rd_byte[zc_pos];
                        zc_next    = zc_reg + 1'b1;
                    end
                    fp_next   = fp_inc[zsc_pkg::FP_W-1:0];
                    frame_end = fp_last;
                    res.kind  = zsc_pkg::KIND_DECODED;
                    res.coeff = dec_val;
                    res.last  = fp_last;
                    res_valid = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // Snapshot the store before the frame clear
        drain_fill = store_next;

        // Return to reset state at frame end
        if (frame_end)
        begin
            for (int b = 0; b < zsc_pkg::SELECTOR_BYTES; b++)
            begin
                store_next[b] = '0;
            end
            zc_next     = '0;
            fp_next     = '0;
            lp_next     = '0;
            failed_next = 1'b0;
        end
    end

    // Control state and selector store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < zsc_pkg::SELECTOR_BYTES; b++)
            begin
                store_reg[b] <= '0;
            end
            zc_reg        <= '0;
            fp_reg        <= '0;
            lp_reg        <= '0;
            failed_reg    <= 1'b0;
            drain_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            store_reg  <= store_next;
            zc_reg     <= zc_next;
            fp_reg     <= fp_next;
            lp_reg     <= lp_next;
            failed_reg <= failed_next;
            // advance the selector drain
            if (snap)
            begin
                drain_cnt_reg <= zsc_pkg::DC_W'(zsc_pkg::SELECTOR_BYTES);
            end
            else if (drain_pop)
            begin
                drain_cnt_reg <= drain_cnt_reg - 1'b1;
            end
            // hold or drop the output beat
            if (res_valid || drain_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload and selector drain shift register
    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_reg <= res;
        end
        else if (drain_pop)
        begin
            out_reg.kind  <= zsc_pkg::KIND_SELECTOR;
            out_reg.data  <= drain_reg[0];
            out_reg.coeff <= '0;
            out_reg.ovf   <= 1'b0;
            out_reg.last  <= (drain_cnt_reg == zsc_pkg::DC_W'(1));
        end
        if (snap)
        begin
            drain_reg <= drain_fill;
        end
        else if (drain_pop)
        begin
            for (int b = 0; b < zsc_pkg::SELECTOR_BYTES - 1; b++)
            begin
                drain_reg[b] <= drain_reg[b + 1];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign result_kind = out_reg.kind;
    assign data_byte   = out_reg.data;
    assign coeff_out   = out_reg.coeff;
    assign overflow    = out_reg.ovf;
    assign last        = out_reg.last;

    // Zero count never passes the selector capacity
    a_zc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(zc_reg) <= zsc_pkg::SELECTOR_BITS)
        else $error("zero count beyond selector capacity");

    // A failed frame has a full selector count
    a_failed_full: assert property (@(posedge clk) disable iff (!rst_n)
        failed_reg |-> (int'(zc_reg) == zsc_pkg::SELECTOR_BITS))
        else $error("frame failed without full selector count");

    // A pending drain keeps an output beat on offer
    a_drain_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_cnt_reg != '0) |=> out_valid_reg)
        else $error("selector drain pending without output beat");

    // Input is held off once a selector snapshot starts the drain
    a_no_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
        snap |=> !in_ready)
        else $error("input accepted during selector drain");

endmodule

FILE: dv/zero_selector_coeff_codec_test.sv
// Self-checking testbench for the zero-selector coefficient codec.
`timescale 1ns / 1ps

module zero_selector_coeff_codec_test;

    // The block drops beats carrying the fourth mode code
    localparam logic [1:0] MODE_IDLE = 2'd3;

    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int RESET_CYCLES   = 6;
    localparam int LONG_HOLD      = 400;
    localparam int TAIL_CYCLES    = 2 * zsc_pkg::SELECTOR_BYTES + 4;
    localparam int REPORT_LIMIT   = 10;

    // Frame state mirror and queue of expected output beats
    class coeff_frame_board;
        zsc_pkg::sel_byte_t        sel_store [zsc_pkg::SELECTOR_BYTES];
        logic [zsc_pkg::ZC_W-1:0]  zero_count;
        logic [zsc_pkg::FP_W-1:0]  frame_pos;
        logic [zsc_pkg::LP_W-1:0]  load_pos;
        bit                        frame_failed;
        zsc_pkg::result_t          expected_q [$];
        int                        mismatches;

        function new();
            clear_frame();
            mismatches = 0;
        endfunction

        function void clear_frame();
            foreach (sel_store[i])
                sel_store[i] = '0;
            zero_count   = '0;
            frame_pos    = '0;
            load_pos     = '0;
            frame_failed = 1'b0;
        endfunction

        // Advance the frame position; report whether this beat closed the frame
        function bit step_frame();
            bit at_end;
            at_end = (int'(frame_pos) == zsc_pkg::COEFFS_PER_FRAME - 1);
            frame_pos++;
            return at_end;
        endfunction

        function void queue_result(logic [1:0] kind, logic [7:0] data, logic [8:0] coeff,
                                   logic ovf, logic last);
            zsc_pkg::result_t r;
            r.kind  = kind;
            r.data  = data;
            r.coeff = coeff;
            r.ovf   = ovf;
            r.last  = last;
            expected_q.push_back(r);
        endfunction

        // Work out the output beats caused by one accepted input beat
        function void note_input(logic [1:0] m, logic [8:0] c, logic [7:0] b);
            int         idx;
            int         bitpos;
            bit         at_end;
            logic [8:0] value;
            idx    = int'(zero_count) >> 3;
            bitpos = int'(zero_count) & 7;
            case (m)
                zsc_pkg::MODE_ENCODE:
                begin
                    // Swallow the rest of a failed frame
                    if (frame_failed)
                    begin
                        if (step_frame())
                            clear_frame();
                        return;
                    end
                    if (c[7:0] == 8'h00)
                    begin
                        if (zero_count >= zsc_pkg::SELECTOR_BITS)
                        begin
                            queue_result(zsc_pkg::KIND_CODED, 8'h00, 9'h000, 1'b1, 1'b1);
                            frame_failed = 1'b1;
                            if (step_frame())
                                clear_frame();
                            return;
                        end
                        sel_store[idx][bitpos] = sel_store[idx][bitpos] | c[8];
                        zero_count++;
                    end
                    at_end = step_frame();
                    queue_result(zsc_pkg::KIND_CODED, c[7:0], 9'h000, 1'b0, 1'b0);
                    if (at_end)
                    begin
                        for (int i = 0; i < zsc_pkg::SELECTOR_BYTES; i++)
                            queue_result(zsc_pkg::KIND_SELECTOR, sel_store[i], 9'h000, 1'b0,
                                         i == zsc_pkg::SELECTOR_BYTES - 1);
                        clear_frame();
                    end
                end
                zsc_pkg::MODE_LOAD:
                begin
                    sel_store[load_pos] = b;
                    if (int'(load_pos) == zsc_pkg::SELECTOR_BYTES - 1)
                        load_pos = '0;
                    else
                        load_pos++;
                end
                zsc_pkg::MODE_DECODE:
                begin
                    value = {1'b0, b};
                    // Restore bit 8 while selector bits remain
                    if (b == 8'h00 && zero_count < zsc_pkg::SELECTOR_BITS)
                    begin
                        value[8] = sel_store[idx][bitpos];
                        zero_count++;
                    end
                    at_end = step_frame();
                    queue_result(zsc_pkg::KIND_DECODED, 8'h00, value, 1'b0, at_end);
                    if (at_end)
                        clear_frame();
                end
                default:
                begin
                end
            endcase
        endfunction

        // Compare one output beat against the oldest expectation
        function void check_result(zsc_pkg::result_t got);
            zsc_pkg::result_t want;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("%0t: unexpected beat kind=%0d data=%02h coeff=%03h %s",
                             $time, got.kind, got.data, got.coeff,
                             $sformatf("ovf=%0b last=%0b", got.ovf, got.last));
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind || got.data !== want.data || got.coeff !== want.coeff ||
                got.ovf !== want.ovf || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: mismatch expected kind=%0d data=%02h coeff=%03h %s",
                             $time, want.kind, want.data, want.coeff,
                             $sformatf("ovf=%0b last=%0b", want.ovf, want.last));
                    $display("%0t:          actual kind=%0d data=%02h coeff=%03h %s",
                             $time, got.kind, got.data, got.coeff,
                             $sformatf("ovf=%0b last=%0b", got.ovf, got.last));
                end
            end
        endfunction

        function bit clean();
            return mismatches == 0 && expected_q.size() == 0;
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] mode;
    logic [8:0] coeff_in;
    logic [7:0] code_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] result_kind;
    logic [7:0] data_byte;
    logic [8:0] coeff_out;
    logic       overflow;
    logic       last;

    coeff_frame_board board = new();

    int src_run_left = 0;
    bit src_quiet    = 1'b0;
    int cycle_count  = 0;

    zero_selector_coeff_codec dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .coeff_in    (coeff_in),
        .code_byte   (code_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_kind (result_kind),
        .data_byte   (data_byte),
        .coeff_out   (coeff_out),
        .overflow    (overflow),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Alternate runs of random gaps with runs of back-to-back beats
    function automatic int draw_gap(inout int run_left, inout bit quiet);
        if (run_left == 0)
        begin
            run_left = $urandom_range(20, 80);
            quiet    = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        return quiet ? 0 : $urandom_range(0, 19);
    endfunction

    // Coefficient with a zero or non-zero low byte; bit 8 rarely set on non-zero bytes
    function automatic logic [8:0] pick_coeff(bit want_zero);
        logic [7:0] low;
        if (want_zero)
            return {1'($urandom_range(0, 1)), 8'h00};
        low = 8'($urandom_range(1, 255));
        return {1'($urandom_range(0, 15) == 0), low};
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_item(input logic [1:0] m, input logic [8:0] c, input logic [7:0] b);
        int gap;
        gap = draw_gap(src_run_left, src_quiet);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        coeff_in  <= c;
        code_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(m, c, b);
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_item(2'($urandom_range(0, 3)), 9'($urandom_range(0, 511)),
                      ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
    endtask

    // Stimulus and end of run
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        mode      <= zsc_pkg::MODE_ENCODE;
        coeff_in  <= '0;
        code_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes and each mode
        send_item(zsc_pkg::MODE_ENCODE, 9'h000, 8'h00);
        send_item(zsc_pkg::MODE_ENCODE, 9'h100, 8'hFF);
        send_item(zsc_pkg::MODE_ENCODE, 9'h0FF, 8'h00);
        send_item(zsc_pkg::MODE_ENCODE, 9'h001, 8'hFF);
        send_item(zsc_pkg::MODE_ENCODE, 9'h1FF, 8'h5A);
        send_item(zsc_pkg::MODE_ENCODE, 9'h101, 8'h00);
        send_item(zsc_pkg::MODE_ENCODE, 9'h180, 8'h00);
        send_item(MODE_IDLE,            9'h1FF, 8'hFF);
        send_item(zsc_pkg::MODE_LOAD,   9'h1FF, 8'hFF);
        send_item(zsc_pkg::MODE_LOAD,   9'h000, 8'h00);
        send_item(zsc_pkg::MODE_LOAD,   9'h000, 8'hA5);
        send_item(zsc_pkg::MODE_DECODE, 9'h000, 8'h00);
        send_item(zsc_pkg::MODE_DECODE, 9'h1FF, 8'hFF);
        send_item(zsc_pkg::MODE_DECODE, 9'h000, 8'h00);
        send_item(zsc_pkg::MODE_DECODE, 9'h000, 8'h01);
        send_item(zsc_pkg::MODE_DECODE, 9'h000, 8'h80);
        send_item(MODE_IDLE,            9'h000, 8'h00);
        send_item(zsc_pkg::MODE_ENCODE, 9'h100, 8'h00);
        send_item(zsc_pkg::MODE_ENCODE, 9'h000, 8'h00);

        // Fill the selector with mostly zero bytes until the frame overflows
        while (!board.frame_failed)
            send_item(zsc_pkg::MODE_ENCODE, pick_coeff($urandom_range(0, 7) != 0),
                      8'($urandom));

        // Mixed beats on the failed frame: swallowed encodes, loads, saturated decodes
        send_noise(15);
        in_valid <= 1'b0;

        // Drain outstanding beats, then allow for stray output
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.clean())
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Output side: random stalls plus two long hold-offs to back up the input
    initial
    begin
        int gap;
        int run_left;
        bit quiet;
        int beats;
        run_left = 0;
        quiet    = 1'b0;
        beats    = 0;
        out_ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (beats == 20 || beats == 60)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = draw_gap(run_left, quiet);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            beats++;
        end
    end

    // Check every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result({result_kind, data_byte, coeff_out, overflow, last});
    end

    // Guard against a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

FILE: zero_selector_coeff_codec.f
sv/zsc_pkg.sv
sv/zero_selector_coeff_codec.sv
dv/zero_selector_coeff_codec_test.sv
